### rtl/heading_fusion_with_tilt_fallback_macros.svh
// Assertion macros for the heading fusion block.
// Used by the top level only; compiled out under SYNTHESIS.
`ifndef HEADING_FUSION_WITH_TILT_FALLBACK_MACROS_SVH
`define HEADING_FUSION_WITH_TILT_FALLBACK_MACROS_SVH
`ifndef SYNTHESIS
`define HFTF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define HFTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HFTF_ASSERT_IMP(lbl, ante, cons, msg)
`define HFTF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/hftf_pkg.sv
// Shared types and constants for the heading fusion block.
// No dependencies.
`default_nettype none
package hftf_pkg;
  localparam int unsigned ZW     = 23;  // CORDIC angle, 1/4096 degree
  localparam int unsigned CW     = 36;  // CORDIC x/y datapath
  localparam int unsigned OW     = 18;  // CORDIC operand width
  localparam logic signed [ZW-1:0] HalfTurnFine = 23'sd737280;

  localparam logic [2:0] CfgMagX     = 3'd0;
  localparam logic [2:0] CfgMagY     = 3'd1;
  localparam logic [2:0] CfgTrim     = 3'd2;
  localparam logic [2:0] CfgInterval = 3'd3;
  localparam logic [2:0] CfgTilt     = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 23'sd184320;
      5'd1:  v = 23'sd108810;
      5'd2:  v = 23'sd57492;
      5'd3:  v = 23'sd29184;
      5'd4:  v = 23'sd14649;
      5'd5:  v = 23'sd7331;
      5'd6:  v = 23'sd3667;
      5'd7:  v = 23'sd1833;
      5'd8:  v = 23'sd917;
      5'd9:  v = 23'sd458;
      5'd10: v = 23'sd229;
      5'd11: v = 23'sd115;
      5'd12: v = 23'sd57;
      5'd13: v = 23'sd29;
      5'd14: v = 23'sd14;
      5'd15: v = 23'sd7;
      5'd16: v = 23'sd4;
      5'd17: v = 23'sd2;
      5'd18: v = 23'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

### rtl/hftf_cordic.sv
// Iterative vectoring CORDIC: atan2(y, x) in 1/4096 degree, one step a cycle.
// Depends on hftf_pkg.
`default_nettype none
module hftf_cordic #(
  parameter int unsigned Steps = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [hftf_pkg::OW-1:0]    y_i,
  input  wire logic signed [hftf_pkg::OW-1:0]    x_i,
  output hftf_pkg::unit_stat_t                   stat_o,
  output logic signed [hftf_pkg::ZW-1:0]         z_o
);
  localparam int unsigned CntW = $clog2(Steps);

  logic                             busy_q, done_q;
  logic [CntW-1:0]                  cnt_q;
  logic signed [hftf_pkg::CW-1:0]   x_q, y_q, xs, ys, xe, ye;
  logic signed [hftf_pkg::ZW-1:0]   z_q;

  assign xe = hftf_pkg::CW'(x_i);
  assign ye = hftf_pkg::CW'(y_i);
  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // zero vector: answer at once
      done_q <= (start_i && x_i == '0 && y_i == '0) ||
                (!start_i && busy_q && cnt_q == CntW'(Steps - 1));
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= !(x_i == '0 && y_i == '0);
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (x_i < 0) begin
        z_q <= (y_i >= 0) ? hftf_pkg::HalfTurnFine : -hftf_pkg::HalfTurnFine;
        x_q <= (-xe) <<< 14;
        y_q <= (-ye) <<< 14;
      end else begin
        z_q <= '0;
        x_q <= xe <<< 14;
        y_q <= ye <<< 14;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + hftf_pkg::atan_tab(5'(cnt_q));
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - hftf_pkg::atan_tab(5'(cnt_q));
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign z_o = z_q;
endmodule
`default_nettype wire

### rtl/hftf_isqrt.sv
// Iterative floor square root of a 32-bit value, one result bit a cycle.
// Depends on hftf_pkg.
`default_nettype none
module hftf_isqrt (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [31:0]       v_i,
  output hftf_pkg::unit_stat_t   stat_o,
  output logic [15:0]            root_o
);
  logic        busy_q, done_q;
  logic [31:0] rem_q, r_q, bit_q, trial;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= v_i;
      r_q   <= '0;
      bit_q <= 32'h4000_0000;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        r_q   <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o = r_q[15:0];
endmodule
`default_nettype wire

### rtl/heading_fusion_with_tilt_fallback.sv
// Channel  | dir | signals                      | payload
// s_axis   | in  | tvalid/tready/tdata[175:0]   | one IMU sample
// m_axis   | out | tvalid/tready/tdata/tuser    | heading, level flag
// cfg      | in  | we/idx/wdata                 | five setup registers
//
// Each sample runs two square roots, four CORDIC runs and three reciprocal
// divides; the squares, the blends and the divides share one multiplier. Ready
// is high only while idle; a finished result waits in the output register,
// and the block stalls before writing a new one until it is taken. Reset
// clears the sequencer, the yaw gap, the offsets and the trim, and sets the
// interval register to 100 and the tilt register to 48.
`default_nettype none
`include "heading_fusion_with_tilt_fallback_macros.svh"
module heading_fusion_with_tilt_fallback #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // euler_heading, euler_roll, euler_pitch, rate_x, rate_y, rate_z,
  // accel_x, accel_y, accel_z, field_x, field_y (16 bits each)
  input  wire logic [175:0]  s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [15:0]        m_axis_tdata_o,   // heading[14:0], zero pad
  output logic               m_axis_tuser_o,   // level_flag
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [15:0]   cfg_wdata_i
);
  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ1, ST_SQ2, ST_RT1, ST_SQ3, ST_SQ4, ST_RT2,
    ST_ANG, ST_ANGW, ST_F1, ST_F2, ST_F3, ST_F4, ST_DIVS, ST_QM, ST_QB, ST_QC,
    ST_FIN
  } state_e;

  localparam logic [35:0]        DivConst   = 36'd125000;
  localparam logic signed [18:0] DivMul     = 19'sd125000;
  // floor(2^26 * 256 / 125000), so the estimate is never above the quotient
  localparam logic signed [18:0] RecipConst = 19'sd137438;

  state_e state_q;
  logic [1:0] k_q;
  logic [17:0] quot_q;
  logic [35:0] rem_q;
  logic sq_start_q, cd_start_q, out_valid_q, out_level_q;
  logic [14:0] out_head_q;
  logic signed [16:0] gap_q;
  logic signed [15:0] off_x_q, off_y_q;
  logic signed [13:0] trim_q;
  logic [9:0] intv_q;
  logic [11:0] tilt_q;

  logic signed [15:0] eh_q, er_q, ep_q, rx_q, ry_q, rz_q, ax_q, ay_q, az_q, fx_q, fy_q;
  logic [15:0] s1_q, s2_q;
  logic signed [47:0] acc_q;
  logic signed [22:0] at_q;
  logic signed [18:0] roll_q, pitch_q, yaw_q;

  hftf_pkg::unit_stat_t cd_stat, sq_stat;
  logic signed [22:0] cd_z;
  logic [15:0] sq_root;
  logic signed [17:0] cd_y, cd_x;

  hftf_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start_q), .v_i(acc_q[31:0]),
    .stat_o(sq_stat), .root_o(sq_root)
  );

  hftf_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cd_start_q), .y_i(cd_y), .x_i(cd_x),
    .stat_o(cd_stat), .z_o(cd_z)
  );

  // CORDIC operands per angle
  always_comb begin
    unique case (k_q)
      2'd0: begin cd_y = 18'(ay_q); cd_x = 18'(az_q); end
      2'd1: begin cd_y = -18'(ax_q); cd_x = $signed({2'b00, s1_q}); end
      2'd2: begin cd_y = -18'(az_q); cd_x = $signed({2'b00, s2_q}); end
      default: begin
        cd_y = 18'(off_x_q) - 18'(fx_q);
        cd_x = 18'(off_y_q) - 18'(fy_q);
      end
    endcase
  end

  // fuse operands: roll takes euler_pitch and rate_z, yaw euler_heading and rate_x
  logic signed [15:0] fe, fr;
  always_comb begin
    unique case (k_q)
      2'd0:    begin fe = ep_q; fr = rz_q; end
      2'd1:    begin fe = er_q; fr = ry_q; end
      default: begin fe = eh_q; fr = rx_q; end
    endcase
  end

  // shared multiplier
  logic signed [27:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [46:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ1, ST_SQ4: begin mul_a = 28'(ay_q); mul_b = 19'(ay_q); end
      ST_SQ2:         begin mul_a = 28'(az_q); mul_b = 19'(az_q); end
      ST_SQ3:         begin mul_a = 28'(ax_q); mul_b = 19'(ax_q); end
      ST_F1:          begin mul_a = 28'(fe); mul_b = 19'sd1000; end
      ST_F2:          begin mul_a = 28'(fr); mul_b = $signed({9'd0, intv_q}); end
      ST_F3:          begin mul_a = acc_q[27:0]; mul_b = 19'sd254720; end
      ST_F4:          begin mul_a = 28'(at_q); mul_b = 19'sd5000; end
      ST_QM:          begin mul_a = $signed({1'b0, rem_q[34:8]}); mul_b = RecipConst; end
      ST_QB:          begin mul_a = $signed({10'd0, quot_q}); mul_b = DivMul; end
      default: ;
    endcase
  end
  assign prod = 47'(mul_a) * 47'(mul_b);

  // divide setup: floor((n + 128000000) / 2^11) biased to stay non-negative
  logic signed [47:0] rnd, sh;
  logic [35:0] rem_init;
  assign rnd = acc_q + 48'sd128000000;
  assign sh = rnd >>> 11;
  assign rem_init = 36'(sh + 48'sd16384000000);
  logic signed [18:0] fused;
  assign fused = $signed({1'b0, quot_q}) - 19'sd131072;

  // compass heading and final selection
  logic signed [23:0] d0, d1;
  logic signed [15:0] comp0, comp1, comp;
  logic signed [19:0] ab_r, ab_p, gdiff, fb0, fb1, head_w;
  logic signed [16:0] gap_new;
  logic level;
  always_comb begin
    d0 = -24'(at_q);
    d1 = (d0 < 0) ? d0 + 24'sd1474560 : d0;
    comp0 = 16'((d1 + 24'sd128) >>> 8);
    comp1 = comp0 + 16'(trim_q);
    if (comp1 < 0) comp = comp1 + 16'sd5760;
    else if (comp1 > 16'sd5760) comp = comp1 - 16'sd5760;
    else comp = comp1;
    ab_r = (roll_q < 0) ? -20'(roll_q) : 20'(roll_q);
    ab_p = (pitch_q < 0) ? -20'(pitch_q) : 20'(pitch_q);
    level = !(ab_r > $signed({8'd0, tilt_q}) || ab_p > $signed({8'd0, tilt_q}));
    gdiff = 20'(yaw_q) - 20'(comp);
    if (gdiff > 20'sd65535) gap_new = 17'sd65535;
    else if (gdiff < -20'sd65536) gap_new = -17'sd65536;
    else gap_new = 17'(gdiff);
    fb0 = 20'(yaw_q) - 20'(gap_q);
    if (fb0 < 0) fb1 = fb0 + 20'sd5760;
    else if (fb0 > 20'sd5760) fb1 = fb0 - 20'sd5760;
    else fb1 = fb0;
    if (level) head_w = 20'(comp);
    else if (fb1 > 20'sd11520) head_w = 20'sd11520;
    else if (fb1 < -20'sd5760) head_w = -20'sd5760;
    else head_w = fb1;
  end

  logic s_fire, fin_go;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign fin_go = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      sq_start_q  <= 1'b0;
      cd_start_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_level_q <= 1'b0;
      out_head_q  <= '0;
      gap_q       <= '0;
      off_x_q     <= '0;
      off_y_q     <= '0;
      trim_q      <= '0;
      intv_q      <= 10'd100;
      tilt_q      <= 12'd48;
    end else begin
      sq_start_q <= (state_q == ST_SQ2) || (state_q == ST_SQ4);
      cd_start_q <= (state_q == ST_ANG);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hftf_pkg::CfgMagX:     off_x_q <= cfg_wdata_i;
          hftf_pkg::CfgMagY:     off_y_q <= cfg_wdata_i;
          hftf_pkg::CfgTrim:     trim_q  <= cfg_wdata_i[13:0];
          hftf_pkg::CfgInterval: intv_q  <= cfg_wdata_i[9:0];
          hftf_pkg::CfgTilt:     tilt_q  <= cfg_wdata_i[11:0];
          default: ;
        endcase
      end
      if (fin_go) out_valid_q <= 1'b1;
      else if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (s_fire) state_q <= ST_SQ1;
        ST_SQ1:  state_q <= ST_SQ2;
        ST_SQ2:  state_q <= ST_RT1;
        ST_RT1:  if (sq_stat.done) state_q <= ST_SQ3;
        ST_SQ3:  state_q <= ST_SQ4;
        ST_SQ4:  state_q <= ST_RT2;
        ST_RT2:  if (sq_stat.done) begin state_q <= ST_ANG; k_q <= '0; end
        ST_ANG:  state_q <= ST_ANGW;
        ST_ANGW: if (cd_stat.done) state_q <= (k_q == 2'd3) ? ST_FIN : ST_F1;
        ST_F1:   state_q <= ST_F2;
        ST_F2:   state_q <= ST_F3;
        ST_F3:   state_q <= ST_F4;
        ST_F4:   state_q <= ST_DIVS;
        ST_DIVS: state_q <= ST_QM;
        ST_QM:   state_q <= ST_QB;
        ST_QB:   state_q <= ST_QC;
        ST_QC: begin
          if (rem_q < DivConst) begin
            state_q <= ST_ANG;
            k_q <= k_q + 1'b1;
          end
        end
        ST_FIN: if (fin_go) begin
          state_q     <= ST_IDLE;
          out_head_q  <= head_w[14:0];
          out_level_q <= level;
          if (level) gap_q <= gap_new;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      eh_q <= s_axis_tdata_i[15:0];
      er_q <= s_axis_tdata_i[31:16];
      ep_q <= s_axis_tdata_i[47:32];
      rx_q <= s_axis_tdata_i[63:48];
      ry_q <= s_axis_tdata_i[79:64];
      rz_q <= s_axis_tdata_i[95:80];
      ax_q <= s_axis_tdata_i[111:96];
      ay_q <= s_axis_tdata_i[127:112];
      az_q <= s_axis_tdata_i[143:128];
      fx_q <= s_axis_tdata_i[159:144];
      fy_q <= s_axis_tdata_i[175:160];
    end
    case (state_q)
      ST_SQ1, ST_SQ3, ST_F1, ST_F3: acc_q <= 48'(prod);
      ST_SQ2, ST_SQ4, ST_F2, ST_F4: acc_q <= acc_q + 48'(prod);
      default: ;
    endcase
    if (state_q == ST_RT1 && sq_stat.done) s1_q <= sq_root;
    if (state_q == ST_RT2 && sq_stat.done) s2_q <= sq_root;
    if (state_q == ST_ANGW && cd_stat.done) at_q <= cd_z;
    // estimate the quotient at most two low, then correct by subtraction
    case (state_q)
      ST_DIVS: rem_q <= rem_init;
      ST_QM:   quot_q <= prod[43:26];
      ST_QB:   rem_q <= rem_q - 36'(prod);
      ST_QC: begin
        if (rem_q >= DivConst) begin
          rem_q  <= rem_q - DivConst;
          quot_q <= quot_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q == ST_ANG && k_q != 2'd0) begin
      // commit the previous fused angle
      unique case (k_q)
        2'd1:    roll_q  <= fused;
        2'd2:    pitch_q <= fused;
        default: yaw_q   <= fused;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_head_q};
  assign m_axis_tuser_o  = out_level_q;

  `HFTF_ASSERT_NXT(a_busy_after_take, s_fire, !s_axis_tready_o, "ready after transfer")
  `HFTF_ASSERT_IMP(a_level_in_turn, m_axis_tvalid_o && m_axis_tuser_o,
    !out_head_q[14] && out_head_q <= 15'd5760, "compass heading out of 0..5760")
  `HFTF_ASSERT_IMP(a_units_exclusive, cd_stat.busy, !sq_stat.busy,
    "root and CORDIC both busy")
endmodule
`default_nettype wire

### test/tb_heading_fusion_with_tilt_fallback.sv
// Testbench for heading_fusion_with_tilt_fallback: streams IMU samples and checks
// every heading and level flag against a built-in predictor of the fusion maths.
// Depends on hftf_pkg and the block under test only.
`timescale 1ns / 1ps
`default_nettype none
module tb_heading_fusion_with_tilt_fallback;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam longint     FullTurn     = 5760;
  localparam longint     FullTurnFine = 1474560;
  localparam longint     HalfFine     = 737280;
  localparam int         Drain        = 400;
  localparam longint     CycleLimit   = 4_000_000;

  typedef logic signed [15:0] sample_t [0:10];
  typedef struct {
    logic [14:0] hd;
    logic        lvl;
  } heading_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [175:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_idx = hftf_pkg::CfgMagX;
  logic [15:0]  cfg_wdata = '0;

  heading_t     heading_q[$];
  int           errs = 0;
  int           n_sent = 0, n_level = 0, n_tilt = 0;
  int           send_idle_pct = 0, recv_stall_pct = 0;
  longint       cycles = 0;

  // predictor copy of the setup registers and the yaw gap
  longint       mag_x_c, mag_y_c, trim_c, interval_c, tilt_c, gap_c;
  longint       atan_lut [0:23] = '{184320, 108810, 57492, 29184, 14649, 7331, 3667,
                                    1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1,
                                    0, 0, 0, 0, 0};

  heading_fusion_with_tilt_fallback #(.CORDIC_STEPS(CORDIC_STEPS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               heading_q.size());
      $display("tb_heading_fusion_with_tilt_fallback: done, errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // vectoring CORDIC, angle in 1/4096 degree
  function automatic longint vec_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HalfFine : -HalfFine;
      x = -x;
      y = -y;
    end
    x *= 16384;
    y *= 16384;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_lut[i];
      end else begin
        x -= ys; y += xs; z -= atan_lut[i];
      end
    end
    return z;
  endfunction

  function automatic longint blend(longint e, longint r, longint at);
    longint base;
    base = e * 1000 + r * interval_c;
    return floor_div(995 * 256 * base + 5000 * at + 128000000, 256000000);
  endfunction

  function automatic longint wrap_turn(longint h);
    if (h < 0) return h + FullTurn;
    if (h > FullTurn) return h - FullTurn;
    return h;
  endfunction

  function automatic heading_t predict_heading(sample_t s);
    longint eh, er, ep, rx, ry, rz, ax, ay, az, mx, my;
    longint roll, pitch, yaw, d, comp, h, g;
    logic lvl;
    heading_t res;
    eh = s[0]; er = s[1]; ep = s[2];
    rx = s[3]; ry = s[4]; rz = s[5];
    ax = s[6]; ay = s[7]; az = s[8];
    roll  = blend(ep, rz, vec_angle(ay, az));
    pitch = blend(er, ry, vec_angle(-ax, int_root(ay * ay + az * az)));
    yaw   = blend(eh, rx, vec_angle(-az, int_root(ax * ax + ay * ay)));
    mx = longint'(s[9]) - mag_x_c;
    my = longint'(s[10]) - mag_y_c;
    d = -vec_angle(-mx, -my);
    if (d < 0) d += FullTurnFine;
    comp = wrap_turn(floor_div(d + 128, 256) + trim_c);
    lvl = !((roll < 0 ? -roll : roll) > tilt_c || (pitch < 0 ? -pitch : pitch) > tilt_c);
    if (lvl) begin
      g = yaw - comp;
      if (g > 65535) g = 65535;
      if (g < -65536) g = -65536;
      gap_c = g;
      h = comp;
    end else begin
      h = wrap_turn(yaw - gap_c);
    end
    if (h > 11520) h = 11520;
    if (h < -5760) h = -5760;
    res.hd = h[14:0];
    res.lvl = lvl;
    return res;
  endfunction

  always @(posedge clk_i) begin
    heading_t e;
    if (rst_ni && m_tvalid && m_tready) begin
      if (heading_q.size() == 0) begin
        errs++;
        $display("%0t: unexpected result heading=%h level=%b", $time, m_tdata, m_tuser);
      end else begin
        e = heading_q.pop_front();
        if (m_tdata !== {1'b0, e.hd} || m_tuser !== e.lvl) begin
          errs++;
          $display("%0t: mismatch expected heading=%h level=%b, got heading=%h level=%b",
                   $time, {1'b0, e.hd}, e.lvl, m_tdata, m_tuser);
        end
        if (e.lvl) n_level++; else n_tilt++;
      end
    end
  end

  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_tvalid = 1'b1;
    for (int i = 0; i < 11; i++) s_tdata[16*i +: 16] = s[i];
    do @(posedge clk_i); while (!s_tready);
    heading_q.push_back(predict_heading(s));
    n_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      hftf_pkg::CfgMagX:     mag_x_c = longint'($signed(val));
      hftf_pkg::CfgMagY:     mag_y_c = longint'($signed(val));
      hftf_pkg::CfgTrim:     trim_c = longint'($signed(val[13:0]));
      hftf_pkg::CfgInterval: interval_c = longint'(val[9:0]);
      hftf_pkg::CfgTilt:     tilt_c = longint'(val[11:0]);
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] mx, logic [15:0] my, logic [15:0] tr,
                          logic [15:0] iv, logic [15:0] tl);
    wait_idle();
    write_reg(hftf_pkg::CfgMagX, mx);
    write_reg(hftf_pkg::CfgMagY, my);
    write_reg(hftf_pkg::CfgTrim, tr);
    write_reg(hftf_pkg::CfgInterval, iv);
    write_reg(hftf_pkg::CfgTilt, tl);
  endtask

  function automatic sample_t mk(int eh, int er, int ep, int rx, int ry, int rz,
                                 int ax, int ay, int az, int fx, int fy);
    sample_t s;
    s[0] = 16'(eh); s[1] = 16'(er); s[2] = 16'(ep); s[3] = 16'(rx);
    s[4] = 16'(ry); s[5] = 16'(rz); s[6] = 16'(ax); s[7] = 16'(ay);
    s[8] = 16'(az); s[9] = 16'(fx); s[10] = 16'(fy);
    return s;
  endfunction

  // mostly near-level samples so the compass path and gap update get exercised
  function automatic sample_t rand_sample();
    sample_t s;
    int      k;
    for (int i = 0; i < 11; i++) s[i] = 16'($urandom());
    k = $urandom_range(9);
    if (k < 6) begin
      for (int i = 1; i < 6; i++) s[i] = 16'($signed($urandom_range(80)) - 40);
      if (k < 3) s[0] = 16'($signed($urandom_range(2000)) - 1000);
    end else if (k == 6) begin
      s[6] = 16'($signed($urandom_range(4)) - 2);
      s[7] = 16'($signed($urandom_range(4)) - 2);
    end
    return s;
  endfunction

  task automatic run_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_sample(rand_sample());
  endtask

  task automatic test_directed();
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                   32767, 32767));
    send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                   -32768, -32768, -32768));
    send_sample(mk(100, 0, 0, 0, 0, 0, 0, 0, 981, 300, 0));
    send_sample(mk(-100, 10, -10, 5, -5, 5, 10, -10, -981, 0, 300));
    send_sample(mk(0, 0, 0, 0, 0, 0, -20, 0, -981, -300, -300));
    send_sample(mk(500, 0, 40, 0, 0, 20, 0, 0, 981, 0, -300));
    send_sample(mk(500, 0, 800, 0, 0, 0, 0, 0, 981, 0, -300));
    send_sample(mk(0, -800, 0, 0, 0, 0, 0, 0, 981, 0, -300));
    // wide gap from an extreme yaw, then a tilted sample to push the fallback
    send_sample(mk(32767, 0, 0, 32767, 0, 0, 0, 0, -32768, 0, 300));
    send_sample(mk(-32768, 0, 2000, -32768, 0, 0, 0, 0, 32767, 1, 1));
    send_sample(mk(-32768, 0, 0, -32768, 0, 0, 0, 0, 32767, -32768, 32767));
    send_sample(mk(32767, 32767, 0, 32767, 0, 0, 0, 0, -32768, 5, 5));
    send_sample(mk(0, 0, 0, 0, 0, 0, 32767, -32768, 0, 32767, -32768));
  endtask

  task automatic test_extreme_regs();
    set_regs(16'h8000, 16'h7fff, -16'sd5760, 16'd1023, 16'd0);
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 981, -32768, 32767));
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 981, 32767, -32768));
    send_sample(mk(100, 0, 0, 32767, 0, 0, 0, 0, 981, 0, 0));
    set_regs(16'h7fff, 16'h8000, 16'sd5760, 16'd0, 16'd4095);
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 981, 32767, -32768));
    send_sample(mk(32767, 20000, -20000, 32767, 32767, 32767, 1, 1, 1, 0, 0));
    run_random(100, 0, 0);
  endtask

  task automatic test_no_idle();
    set_regs(16'd0, 16'd0, 16'd0, 16'd100, 16'd48);
    run_random(450, 0, 0);
  endtask

  task automatic test_sender_idle();
    set_regs(16'sd120, -16'sd250, 16'sd200, 16'd1000, 16'd2880);
    run_random(220, 79, 0);
    // hold off the sender until the block has drained
    wait_idle();
    run_random(220, 79, 0);
  endtask

  task automatic test_receiver_stall();
    set_regs(-16'sd500, 16'sd40, -16'sd100, 16'd20, 16'd16);
    run_random(430, 0, 79);
  endtask

  task automatic test_both_idle();
    set_regs(16'sd7, 16'sd0, 16'sd5, 16'd500, 16'd200);
    run_random(430, 28, 28);
  endtask

  initial begin
    mag_x_c = 0; mag_y_c = 0; trim_c = 0; interval_c = 100; tilt_c = 48; gap_c = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_extreme_regs();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    wait_idle();
    $display("sent %0d samples over six register settings and four flow-control phases",
             n_sent);
    $display("checked %0d compass headings and %0d yaw fallbacks", n_level, n_tilt);
    if (errs == 0) begin
      $display("tb_heading_fusion_with_tilt_fallback: done, clean");
    end else begin
      $display("tb_heading_fusion_with_tilt_fallback: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
